### design/fpcc_pkg.sv
// fpcc_pkg: shared types and constants of the front panel channel controller
// request and result structs, operation codes, register indexes, timer constants
// no dependencies
`timescale 1ns / 1ps

package fpcc_pkg;

  typedef enum logic [2:0] {
    OP_PASS      = 3'd0,
    OP_LOCK      = 3'd1,
    OP_UNLOCK    = 3'd2,
    OP_CALIBRATE = 3'd3,
    OP_POWER_OFF = 3'd4,
    OP_INIT      = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT  = 3'd0,
    REG_BATT_LOW       = 3'd1,
    REG_BATT_HIGH      = 3'd2,
    REG_POWER_HOLD     = 3'd3,
    REG_DWELL_STEADY   = 3'd4,
    REG_DWELL_TOGGLING = 3'd5
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [31:0] PERIOD_10MS   = 32'd10;
  localparam logic [31:0] PERIOD_50MS   = 32'd50;
  localparam logic [31:0] PERIOD_100MS  = 32'd100;
  localparam logic [31:0] PERIOD_1000MS = 32'd1000;
  localparam logic [2:0]  BLINK_DIV     = 3'd5;
  localparam logic [4:0]  LASER_DIV     = 5'd25;
  localparam logic [7:0]  HOLD_MAX      = 8'd255;
  localparam logic [3:0]  SCAN_MAX      = 4'd15;
  localparam logic [1:0]  REPEAT_MAX    = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] time_ms;
    logic        key_up;
    logic        key_dn;
    logic        key_power;
    logic [6:0]  battery_percent;
  } req_t;

  typedef struct packed {
    logic       channel_cmd_valid;
    logic [3:0] channel_sel;
    logic       laser_toggle_pulse;
    logic       laser_toggle_reset;
    logic       red_led;
    logic       auto_led;
    logic       usb_init;
    logic       power_off_request;
    logic       shutdown;
  } res_t;

  typedef struct packed {
    logic [4:0] channel_count;
    logic [6:0] battery_low_pct;
    logic [6:0] battery_high_pct;
    logic [7:0] power_hold_steps;
    logic [3:0] scan_dwell_steady;
    logic [3:0] scan_dwell_toggling;
  } cfg_t;

endpackage

### design/fpcc_cfg.sv
// fpcc_cfg: apb register file for the controller settings
// depends on fpcc_pkg (cfg_t, register indexes, bus widths)
`timescale 1ns / 1ps

module fpcc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpcc_pkg::ADDR_W-1:0] paddr,
  input  logic [fpcc_pkg::DATA_W-1:0] pwdata,
  output logic [fpcc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output fpcc_pkg::cfg_t             cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count       <= 5'd4;
      cfg.battery_low_pct     <= 7'd10;
      cfg.battery_high_pct    <= 7'd20;
      cfg.power_hold_steps    <= 8'd40;
      cfg.scan_dwell_steady   <= 4'd5;
      cfg.scan_dwell_toggling <= 4'd10;
    end else if (wr) begin
      unique case (idx)
        fpcc_pkg::REG_CHANNEL_COUNT:  cfg.channel_count       <= pwdata[4:0];
        fpcc_pkg::REG_BATT_LOW:       cfg.battery_low_pct     <= pwdata[6:0];
        fpcc_pkg::REG_BATT_HIGH:      cfg.battery_high_pct    <= pwdata[6:0];
        fpcc_pkg::REG_POWER_HOLD:     cfg.power_hold_steps    <= pwdata[7:0];
        fpcc_pkg::REG_DWELL_STEADY:   cfg.scan_dwell_steady   <= pwdata[3:0];
        fpcc_pkg::REG_DWELL_TOGGLING: cfg.scan_dwell_toggling <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      fpcc_pkg::REG_CHANNEL_COUNT:  prdata = {27'd0, cfg.channel_count};
      fpcc_pkg::REG_BATT_LOW:       prdata = {25'd0, cfg.battery_low_pct};
      fpcc_pkg::REG_BATT_HIGH:      prdata = {25'd0, cfg.battery_high_pct};
      fpcc_pkg::REG_POWER_HOLD:     prdata = {24'd0, cfg.power_hold_steps};
      fpcc_pkg::REG_DWELL_STEADY:   prdata = {28'd0, cfg.scan_dwell_steady};
      fpcc_pkg::REG_DWELL_TOGGLING: prdata = {28'd0, cfg.scan_dwell_toggling};
      default:                      prdata = '0;
    endcase
  end

endmodule

### design/front_panel_channel_controller.sv
// front_panel_channel_controller: front panel key, scan, laser and battery led control
// depends on fpcc_pkg and fpcc_cfg
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_valid/req_stall/req_data): one request per main-loop pass
//   (keys, time, battery) or one command (lock, unlock, calibrate, power-off, init).
//   Result channel (res_valid/res_stall/res_data): exactly one result per request,
//   in request order.
//   Settings must be written over the apb port only while the block is idle; the
//   block itself does not enforce this. pready is tied high.
//   Throughput: one request per cycle while res_stall is low. The request register
//   and the result register form a two-stage pipe; the step logic between them reads and
//   updates the panel state together with the result, so consecutive requests see each other's effects.
//   Stall: while the result waits under res_stall, one more request is still taken
//   into the request register; req_stall rises only when both stages are full.
//   Reset (rst, synchronous): both stages empty, panel state cleared with the
//   start-up flag set, settings back to their defaults.

module front_panel_channel_controller #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  fpcc_pkg::req_t              req_data,
  output logic                        res_valid,
  input  logic                        res_stall,
  output fpcc_pkg::res_t              res_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpcc_pkg::ADDR_W-1:0] paddr,
  input  logic [fpcc_pkg::DATA_W-1:0] pwdata,
  output logic [fpcc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  typedef struct packed {
    logic [3:0]       current_channel;
    logic             scan_mode;
    logic             keys_locked;
    logic [1:0]       up_repeat;
    logic [1:0]       down_repeat;
    logic             power_held;
    logic [7:0]       power_hold_count;
    logic             laser_toggling;
    logic             low_battery_blink;
    logic             red_level;
    logic [2:0]       blink_count;
    logic [4:0]       laser_count;
    logic [3:0]       scan_count;
    logic             starting;
    logic             power_off_latched;
    logic [3:0][31:0] period_refs;
  } state_t;

  localparam logic [8:0] MaxCh = 9'(MAX_CHANNELS);
  localparam state_t StateReset = '{starting: 1'b1, default: '0};

  fpcc_pkg::cfg_t cfg;
  fpcc_pkg::req_t item;
  fpcc_pkg::res_t res_next;
  state_t         st;
  state_t         st_next;
  logic           in_full;
  logic           advance;
  logic [4:0]     n_eff;
  logic [4:0]     top;
  logic [4:0]     ch;
  logic [4:0]     scan_ch;
  logic [3:0]     dwell;
  logic [3:0]     elapsed;

  fpcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance   = in_full && (!res_valid || !res_stall);
  assign req_stall = in_full && !advance;

  // channel count saturated at the build-time limit
  assign n_eff = ({4'd0, cfg.channel_count} > MaxCh) ? MaxCh[4:0] : cfg.channel_count;
  assign top   = (n_eff != 5'd0) ? n_eff - 5'd1 : 5'd0;

  always_comb begin
    elapsed[0] = (item.time_ms - st.period_refs[0]) >= fpcc_pkg::PERIOD_10MS;
    elapsed[1] = (item.time_ms - st.period_refs[1]) >= fpcc_pkg::PERIOD_50MS;
    elapsed[2] = (item.time_ms - st.period_refs[2]) >= fpcc_pkg::PERIOD_100MS;
    elapsed[3] = (item.time_ms - st.period_refs[3]) >= fpcc_pkg::PERIOD_1000MS;
  end

  always_comb begin
    st_next  = st;
    res_next = '0;
    ch       = '0;
    scan_ch  = '0;
    dwell    = '0;
    unique case (item.operation)
      fpcc_pkg::OP_PASS: begin
        // key handling
        if (st.keys_locked) begin
          if (st.starting) begin
            st_next.starting  = 1'b0;
            res_next.usb_init = 1'b1;
          end
          st_next.up_repeat   = '0;
          st_next.down_repeat = '0;
          if (st.power_held) begin
            st_next.power_hold_count = '0;
            st_next.power_held       = 1'b0;
          end
        end else if (item.key_up) begin
          st_next.down_repeat = '0;
          if (st.up_repeat == 2'd0) begin
            st_next.up_repeat = 2'd1;
            if (st.scan_mode) begin
              ch                = 5'd0;
              st_next.scan_mode = 1'b0;
            end else begin
              ch = {1'b0, st.current_channel} + 5'd1;
            end
            if (ch >= n_eff) begin
              st_next.scan_mode = 1'b1;
              ch                = 5'd0;
            end
            st_next.current_channel    = ch[3:0];
            res_next.channel_cmd_valid = 1'b1;
          end else if (st.up_repeat > fpcc_pkg::REPEAT_MAX) begin
            st_next.up_repeat = '0;
          end else begin
            st_next.up_repeat = st.up_repeat + 2'd1;
          end
        end else if (item.key_dn) begin
          st_next.up_repeat = '0;
          if (st.down_repeat == 2'd0) begin
            ch = {1'b0, st.current_channel};
            if (st.scan_mode) begin
              ch                = top;
              st_next.scan_mode = 1'b0;
            end else if (st.current_channel == 4'd0) begin
              st_next.scan_mode = 1'b1;
            end else begin
              ch = ch - 5'd1;
            end
            st_next.current_channel    = ch[3:0];
            res_next.channel_cmd_valid = 1'b1;
            st_next.down_repeat        = 2'd1;
          end else if (st.down_repeat > fpcc_pkg::REPEAT_MAX) begin
            st_next.down_repeat = '0;
          end else begin
            st_next.down_repeat = st.down_repeat + 2'd1;
          end
        end else if (item.key_power) begin
          if (!st.starting) st_next.power_held = 1'b1;
        end else begin
          st_next.up_repeat   = '0;
          st_next.down_repeat = '0;
          if (st.starting) begin
            st_next.starting  = 1'b0;
            res_next.usb_init = 1'b1;
          end
          // power key released: flip laser toggling
          if (st.power_held) begin
            st_next.power_hold_count = '0;
            st_next.power_held       = 1'b0;
            st_next.laser_toggling   = !st.laser_toggling;
            if (st.laser_toggling) res_next.laser_toggle_reset = 1'b1;
            if (!st.low_battery_blink) st_next.red_level = !st.laser_toggling;
          end
        end

        // 10 ms: led blink and laser toggle pacing
        if (elapsed[0]) begin
          st_next.period_refs[0] = item.time_ms;
          if (st_next.low_battery_blink) begin
            if (st_next.blink_count + 3'd1 >= fpcc_pkg::BLINK_DIV) begin
              st_next.red_level   = !st_next.red_level;
              st_next.blink_count = '0;
            end else begin
              st_next.blink_count = st_next.blink_count + 3'd1;
            end
          end else begin
            st_next.blink_count = '0;
          end
          if (st_next.laser_toggling) begin
            if (st_next.laser_count + 5'd1 >= fpcc_pkg::LASER_DIV) begin
              res_next.laser_toggle_pulse = 1'b1;
              st_next.laser_count         = '0;
            end else begin
              st_next.laser_count = st_next.laser_count + 5'd1;
            end
          end else begin
            st_next.laser_count = '0;
          end
        end

        // 50 ms: power long press
        if (elapsed[1]) begin
          st_next.period_refs[1] = item.time_ms;
          if (st_next.power_held) begin
            if (st_next.power_hold_count < fpcc_pkg::HOLD_MAX) begin
              st_next.power_hold_count = st_next.power_hold_count + 8'd1;
            end
            if (st_next.power_hold_count >= cfg.power_hold_steps &&
                !st_next.power_off_latched && !st_next.starting) begin
              st_next.power_off_latched  = 1'b1;
              res_next.power_off_request = 1'b1;
            end
          end
        end

        // 100 ms: auto-scan stepping
        if (elapsed[2]) begin
          st_next.period_refs[2] = item.time_ms;
          if (st_next.scan_mode) begin
            dwell = st_next.laser_toggling ? cfg.scan_dwell_toggling
                                           : cfg.scan_dwell_steady;
            if (st_next.scan_count < fpcc_pkg::SCAN_MAX) begin
              st_next.scan_count = st_next.scan_count + 4'd1;
            end
            if (st_next.scan_count >= dwell) begin
              scan_ch            = {1'b0, st_next.current_channel} + 5'd1;
              st_next.scan_count = '0;
              if (scan_ch >= n_eff) scan_ch = 5'd0;
              st_next.current_channel    = scan_ch[3:0];
              res_next.channel_cmd_valid = 1'b1;
            end
          end else begin
            st_next.scan_count = '0;
          end
        end

        // 1 s: battery check with hysteresis, low test first
        if (elapsed[3]) begin
          st_next.period_refs[3] = item.time_ms;
          if (item.battery_percent <= cfg.battery_low_pct) begin
            st_next.low_battery_blink = 1'b1;
          end else if (item.battery_percent > cfg.battery_high_pct) begin
            st_next.low_battery_blink = 1'b0;
            st_next.red_level         = st_next.laser_toggling;
          end
        end
      end
      fpcc_pkg::OP_LOCK: begin
        st_next.keys_locked    = 1'b1;
        st_next.scan_count     = '0;
        st_next.laser_toggling = 1'b0;
      end
      fpcc_pkg::OP_UNLOCK: begin
        st_next.keys_locked = 1'b0;
      end
      fpcc_pkg::OP_CALIBRATE: begin
        st_next.scan_mode          = 1'b0;
        st_next.laser_toggling     = 1'b0;
        st_next.keys_locked        = 1'b1;
        st_next.red_level          = 1'b0;
        st_next.current_channel    = 4'd0;
        res_next.channel_cmd_valid = 1'b1;
      end
      fpcc_pkg::OP_POWER_OFF: begin
        st_next.red_level         = 1'b0;
        st_next.scan_mode         = 1'b0;
        st_next.low_battery_blink = 1'b0;
        st_next.laser_toggling    = 1'b0;
        st_next.starting          = 1'b1;
        res_next.shutdown         = 1'b1;
      end
      fpcc_pkg::OP_INIT: begin
        st_next.scan_mode          = 1'b1;
        res_next.channel_cmd_valid = 1'b1;
      end
      default: ;
    endcase
    res_next.channel_sel = st_next.current_channel;
    res_next.red_led     = st_next.red_level;
    res_next.auto_led    = st_next.scan_mode;
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!req_stall) begin
      in_full <= req_valid;
    end
    if (!req_stall && req_valid) item <= req_data;
  end

  // panel state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= StateReset;
      res_valid <= 1'b0;
    end else if (advance) begin
      st        <= st_next;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (advance) res_data <= res_next;
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (in_full && res_valid && res_stall))
    else $error("request stalled with a free stage");

  a_poff_latched: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.power_off_request) |-> st.power_off_latched)
    else $error("power-off request without latch");

  a_shutdown_clears_leds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.shutdown) |-> (!res_data.red_led && !res_data.auto_led))
    else $error("shutdown result with leds lit");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_data) && $stable(st)))
    else $error("stalled result or state changed");

endmodule
